// ===== rtl/mbsh_pkg.sv =====
// ----------------------------------------------------------------------------
// MurmurHash1 byte stream hash package
// Shared constants and the command format passed from front to back.
// ----------------------------------------------------------------------------
package mbsh_pkg;

   localparam int KEY_LEN_BITS = 16;

   localparam logic [31:0] MUR_M       = 32'hc6a4a793;
   localparam logic [31:0] SEED_RESET  = 32'd3187;
   localparam int          MIX_SHIFT   = 16;
   localparam int          FIN1_SHIFT  = 10;
   localparam int          FIN2_SHIFT  = 17;
   localparam int          QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                    start;
      logic                    empty;
      logic                    mix_en;
      logic                    finish;
      logic                    mismatch;
      logic [KEY_LEN_BITS-1:0] len;
      logic [31:0]             word;
   } cmd_type;

endpackage

// ===== rtl/mbsh_if.sv =====
// ----------------------------------------------------------------------------
// MurmurHash1 byte stream hash channels
// Valid/ready channels for key bytes and hash results.
// ----------------------------------------------------------------------------
interface mbsh_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  key_byte;
   logic [15:0] key_length;
   logic        first_byte;
   logic        last_byte;

   modport source (output valid, key_byte, key_length, first_byte, last_byte,
                   input ready);
   modport sink (input valid, key_byte, key_length, first_byte, last_byte,
                 output ready);
endinterface

interface mbsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;
   logic        length_mismatch;

   modport source (output valid, hash_value, length_mismatch, input ready);
   modport sink (input valid, hash_value, length_mismatch, output ready);
endinterface

// ===== rtl/murmur1_byte_stream_hash.sv =====
// The front takes one byte per cycle while the two-entry command queue has room.
// The back accepts a command only in its idle state, then steps through its seed, word mix
// and final mix states (FIN1, FIN2) as needed, all through one shared 32 by 32 multiplier.
// Reset is synchronous and clears all key state; the seed returns to 3187.
// ----------------------------------------------------------------------------
// MurmurHash1 byte stream hash
// Hashes keys arriving one byte per item with a configurable seed.
// ----------------------------------------------------------------------------
module murmur1_byte_stream_hash
   import mbsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mbsh_req_if.sink    req_bus,
   mbsh_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0] seed_ff;
   logic        push_valid, push_ready;
   cmd_type     push_cmd;
   logic        pop_valid, pop_ready;
   cmd_type     pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   mbsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (push_valid),
      .cmd       (push_cmd),
      .cmd_ready (push_ready)
   );

   mbsh_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   mbsh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== rtl/mbsh_front.sv =====
// ----------------------------------------------------------------------------
// MurmurHash1 front end
// Accepts key bytes, packs them into words, counts them and issues commands.
// ----------------------------------------------------------------------------
module mbsh_front
   import mbsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mbsh_req_if.sink      req_bus,
   output logic          cmd_valid,
   output cmd_type       cmd,
   input  logic          cmd_ready
);

   localparam logic [KEY_LEN_BITS-1:0] LEN_MAX = {KEY_LEN_BITS{1'b1}};

   logic [23:0]             pw_ff, pw_in;
   logic [1:0]              pos_ff, pos_in;
   logic [KEY_LEN_BITS-1:0] seen_ff, seen_in;
   logic [KEY_LEN_BITS-1:0] ann_ff, ann_in;
   logic                    ovf_ff, ovf_in;

   logic                    accept;
   logic [KEY_LEN_BITS-1:0] len;
   logic [23:0]             base_pw;
   logic [1:0]              base_pos;
   logic [KEY_LEN_BITS-1:0] base_seen;
   logic                    base_ovf;
   logic                    word_done;

   assign req_bus.ready = cmd_ready;
   assign accept = req_bus.valid && req_bus.ready;
   assign len = req_bus.key_length[KEY_LEN_BITS-1:0];

   always_comb begin
      pw_in   = pw_ff;
      pos_in  = pos_ff;
      seen_in = seen_ff;
      ann_in  = ann_ff;
      ovf_in  = ovf_ff;
      cmd     = '0;
      cmd.len = len;
      cmd_valid = 1'b0;
      base_pw   = pw_ff;
      base_pos  = pos_ff;
      base_seen = seen_ff;
      base_ovf  = ovf_ff;
      word_done = 1'b0;

      if (req_bus.first_byte) begin
         base_pw   = '0;
         base_pos  = '0;
         base_seen = '0;
         base_ovf  = 1'b0;
         ann_in    = len;
      end

      if (req_bus.first_byte && (len == '0)) begin
         cmd.start  = 1'b1;
         cmd.empty  = 1'b1;
         cmd.finish = 1'b1;
         cmd_valid  = accept;
         pw_in   = '0;
         pos_in  = '0;
         seen_in = '0;
         ann_in  = '0;
         ovf_in  = 1'b0;
      end else begin
         cmd.start = req_bus.first_byte;
         if (base_pos == 2'd3) begin
            word_done = 1'b1;
            cmd.word  = {req_bus.key_byte, base_pw};
            pw_in     = '0;
            pos_in    = '0;
         end else begin
            pw_in  = base_pw | (24'(req_bus.key_byte) << {base_pos, 3'b000});
            pos_in = base_pos + 2'd1;
         end

         if (base_seen == LEN_MAX) begin
            ovf_in  = 1'b1;
            seen_in = base_seen;
         end else begin
            ovf_in  = base_ovf;
            seen_in = base_seen + 1'b1;
         end

         cmd.mix_en = word_done;
         if (req_bus.last_byte) begin
            cmd.finish   = 1'b1;
            cmd.mismatch = ovf_in || (seen_in != ann_in);
            if (!word_done && (pos_in != 2'd0)) begin
               cmd.mix_en = 1'b1;
               cmd.word   = {8'd0, pw_in};
            end
            pw_in   = '0;
            pos_in  = '0;
            seen_in = '0;
            ann_in  = '0;
            ovf_in  = 1'b0;
         end
         cmd_valid = accept && (req_bus.first_byte || word_done || req_bus.last_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff   <= '0;
         pos_ff  <= '0;
         seen_ff <= '0;
         ann_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         pw_ff   <= pw_in;
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
         ann_ff  <= ann_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

// ===== rtl/mbsh_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// MurmurHash1 command queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mbsh_cmd_queue
   import mbsh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]      count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != (PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/mbsh_back.sv =====
// ----------------------------------------------------------------------------
// MurmurHash1 back end
// Runs seed, word mix and final mix steps through one shared multiplier.
// ----------------------------------------------------------------------------
module mbsh_back
   import mbsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] seed,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   mbsh_rsp_if.source  rsp_bus
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEED = 3'd1;
   localparam logic [2:0] ST_MIX  = 3'd2;
   localparam logic [2:0] ST_FIN1 = 3'd3;
   localparam logic [2:0] ST_FIN2 = 3'd4;

   logic [2:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] h_ff, h_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic        rsp_mis_ff, rsp_mis_in;

   logic [31:0] mul_a;
   logic [31:0] prod;
   logic        out_free;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign cmd_ready = (state_ff == ST_IDLE);
   assign prod      = mul_a * MUR_M;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.hash_value      = rsp_hash_ff;
   assign rsp_bus.length_mismatch = rsp_mis_ff;

   always_comb begin
      unique case (state_ff)
         ST_SEED: mul_a = 32'(cmd_ff.len);
         ST_MIX:  mul_a = h_ff + cmd_ff.word;
         default: mul_a = h_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      h_in         = h_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_mis_in   = rsp_mis_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               if (cmd.start) begin
                  state_in = ST_SEED;
               end else if (cmd.mix_en) begin
                  state_in = ST_MIX;
               end else if (cmd.finish) begin
                  state_in = ST_FIN1;
               end
            end
         end
         ST_SEED: begin
            h_in = seed ^ prod;
            if (cmd_ff.empty) begin
               state_in = ST_FIN1;
            end else if (cmd_ff.mix_en) begin
               state_in = ST_MIX;
            end else if (cmd_ff.finish) begin
               state_in = ST_FIN1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MIX: begin
            h_in     = prod ^ (prod >> MIX_SHIFT);
            state_in = cmd_ff.finish ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            h_in     = prod ^ (prod >> FIN1_SHIFT);
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = prod ^ (prod >> FIN2_SHIFT);
               rsp_mis_in   = cmd_ff.mismatch && !cmd_ff.empty;
               h_in         = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_mis_ff  <= rsp_mis_in;
   end

endmodule

// ===== rtl/mbsh_checker.sv =====
// ----------------------------------------------------------------------------
// MurmurHash1 port checker
// Watches the top level ports for handshake and ordering errors.
// ----------------------------------------------------------------------------
module mbsh_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_key_length,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_hash_value,
   input  logic        rsp_length_mismatch
);

   logic [3:0] pending_ff;
   logic       req_done;
   logic       rsp_done;

   assign req_done = req_valid && req_ready &&
                     (req_last_byte || (req_first_byte && (req_key_length == 16'd0)));
   assign rsp_done = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 4'(req_done) - 4'(rsp_done);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item dropped before it was taken.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hash_value) && $stable(rsp_length_mismatch))
      else $error("Stalled result item changed.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("Result item without a finished key.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result item shown right after reset.");

endmodule

bind murmur1_byte_stream_hash mbsh_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .req_key_length      (req_bus.key_length),
   .req_first_byte      (req_bus.first_byte),
   .req_last_byte       (req_bus.last_byte),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_hash_value      (rsp_bus.hash_value),
   .rsp_length_mismatch (rsp_bus.length_mismatch)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// MurmurHash1 byte stream hash testbench
// Streams keys one byte per item into the hash block under several seeds and
// checks every hash and length flag against a cycle-free predictor. Both
// channels idle in random bursts; the run closes with a stretch of full rate.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [31:0] MULT          = 32'hc6a4a793;
   localparam logic [31:0] SEED_DEFAULT  = 32'd3187;
   localparam int          WORD_SHIFT    = 16;
   localparam int          FIN1_SHIFT    = 10;
   localparam int          FIN2_SHIFT    = 17;
   localparam int          STALL_LIMIT   = 2000;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          TAIL_CYCLES   = 30;
   localparam int          MAX_REPORTS   = 10;

   typedef struct packed {
      logic [7:0]  key_byte;
      logic [15:0] key_length;
      logic        first_byte;
      logic        last_byte;
   } key_item_t;

   typedef struct packed {
      logic [31:0] hash_value;
      logic        length_mismatch;
   } hash_result_t;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   mbsh_req_if req_bus ();
   mbsh_rsp_if rsp_bus ();

   murmur1_byte_stream_hash dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   key_item_t    pending_bytes[$];
   hash_result_t hashes_due[$];
   key_item_t    next_byte;
   hash_result_t oldest_hash;

   logic [31:0] seed_model;
   logic [31:0] acc_model;
   logic [23:0] partial_model;
   logic [1:0]  slot_model;
   logic [15:0] counted_model;
   logic [15:0] announced_model;
   logic        overflow_model;

   logic req_fire;
   bit   calm;
   int   send_gap;
   int   stall_left;
   int   stall_cycles;
   int   error_count;
   int   items_queued;

   function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
      logic [31:0] t;
      t = (h + w) * MULT;
      return t ^ (t >> WORD_SHIFT);
   endfunction

   function automatic logic [31:0] final_avalanche(input logic [31:0] h);
      logic [31:0] t;
      t = h * MULT;
      t = t ^ (t >> FIN1_SHIFT);
      t = t * MULT;
      return t ^ (t >> FIN2_SHIFT);
   endfunction

   function automatic void clear_key_state();
      acc_model       = '0;
      partial_model   = '0;
      slot_model      = '0;
      counted_model   = '0;
      announced_model = '0;
      overflow_model  = 1'b0;
   endfunction

   function automatic void absorb_key_byte(input key_item_t it);
      logic [31:0]  h;
      hash_result_t r;
      if (it.first_byte) begin
         clear_key_state();
         announced_model = it.key_length;
         acc_model = seed_model ^ ({16'h0000, it.key_length} * MULT);
         if (it.key_length == 16'h0000) begin
            r.hash_value = final_avalanche(acc_model);
            r.length_mismatch = 1'b0;
            hashes_due.push_back(r);
            clear_key_state();
            return;
         end
      end
      if (slot_model == 2'd3) begin
         acc_model = mix_word(acc_model, {it.key_byte, partial_model});
         partial_model = '0;
         slot_model = '0;
      end else begin
         partial_model = partial_model | (24'(it.key_byte) << (8 * slot_model));
         slot_model = slot_model + 2'd1;
      end
      if (counted_model == 16'hffff) begin
         overflow_model = 1'b1;
      end else begin
         counted_model = counted_model + 16'd1;
      end
      if (it.last_byte) begin
         h = acc_model;
         if (slot_model != 2'd0) begin
            h = mix_word(h, {8'h00, partial_model});
         end
         r.hash_value = final_avalanche(h);
         r.length_mismatch = overflow_model || (counted_model != announced_model);
         hashes_due.push_back(r);
         clear_key_state();
      end
   endfunction

   function automatic void report_failure(input string what);
      if (error_count < MAX_REPORTS) begin
         $display("ERROR: %s", what);
      end
      error_count++;
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic [15:0] len,
                                      input logic f, input logic l);
      key_item_t it;
      it.key_byte   = b;
      it.key_length = len;
      it.first_byte = f;
      it.last_byte  = l;
      pending_bytes.push_back(it);
      items_queued++;
   endfunction

   function automatic void queue_key(input int count, input logic [15:0] announced,
                                     input logic with_first, input logic with_last);
      logic [15:0] len;
      for (int i = 0; i < count; i++) begin
         len = (i == 0 && with_first) ? announced : 16'($urandom);
         queue_byte(8'($urandom), len, with_first && i == 0,
                    with_last && i == count - 1);
      end
   endfunction

   function automatic void queue_random_sequence();
      int          pick;
      int          n;
      logic [15:0] wrong_len;
      pick = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      wrong_len = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'(n + 1);
      if (pick < 70) begin
         queue_key(n, 16'(n), 1'b1, 1'b1);
      end else if (pick < 80) begin
         queue_key(n, wrong_len, 1'b1, 1'b1);
      end else if (pick < 86) begin
         queue_byte(8'($urandom), 16'h0000, 1'b1, 1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
         queue_key(n, 16'(n), 1'b1, 1'b0);
      end else begin
         queue_key($urandom_range(1, 5), 16'h0000, 1'b0, 1'($urandom_range(0, 1)));
      end
   endfunction

   task automatic queue_random_items(input int count);
      int target;
      target = items_queued + count;
      while (items_queued < target) begin
         queue_random_sequence();
      end
   endtask

   // Returns at a falling edge once every item is taken and every hash has come.
   task automatic drain_results();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_bus.valid || hashes_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic load_seed(input logic [31:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_fire) begin
         if (send_gap != 0 && !calm) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_byte = pending_bytes.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.key_byte   <= next_byte.key_byte;
            req_bus.key_length <= next_byte.key_length;
            req_bus.first_byte <= next_byte.first_byte;
            req_bus.last_byte  <= next_byte.last_byte;
            if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 10);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0 && !calm) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         seed_model = SEED_DEFAULT;
         clear_key_state();
         req_fire     <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (csr_wr_en) begin
            seed_model = csr_wr_data;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (hashes_due.size() == 0) begin
               report_failure($sformatf("unexpected hash %h mismatch %b",
                                        rsp_bus.hash_value, rsp_bus.length_mismatch));
            end else begin
               oldest_hash = hashes_due.pop_front();
               if (rsp_bus.hash_value !== oldest_hash.hash_value ||
                   rsp_bus.length_mismatch !== oldest_hash.length_mismatch) begin
                  report_failure($sformatf("hash %h mismatch %b, expected %h mismatch %b",
                                           rsp_bus.hash_value, rsp_bus.length_mismatch,
                                           oldest_hash.hash_value,
                                           oldest_hash.length_mismatch));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            absorb_key_byte({req_bus.key_byte, req_bus.key_length,
                             req_bus.first_byte, req_bus.last_byte});
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("ERROR: no item accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.key_byte   = '0;
      req_bus.key_length = '0;
      req_bus.first_byte = 1'b0;
      req_bus.last_byte  = 1'b0;
      rsp_bus.ready      = 1'b0;
      calm               = 1'b0;
      error_count        = 0;
      items_queued       = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The empty key ignores its byte and ends the key whatever last_byte holds.
      queue_byte(8'hff, 16'h0000, 1'b1, 1'b0);
      queue_byte(8'h00, 16'h0000, 1'b1, 1'b1);
      queue_byte(8'hff, 16'h0001, 1'b1, 1'b1);
      queue_byte(8'h00, 16'h0001, 1'b1, 1'b1);
      queue_key(4, 16'd4, 1'b1, 1'b1);
      queue_key(3, 16'd3, 1'b1, 1'b1);
      queue_key(2, 16'd2, 1'b1, 1'b1);
      queue_key(5, 16'd5, 1'b1, 1'b1);
      queue_key(2, 16'hffff, 1'b1, 1'b1);
      // Bytes with no first mark continue from the cleared state.
      queue_key(2, 16'h0000, 1'b0, 1'b1);
      // A new first mark restarts a key that never saw its last byte.
      queue_key(2, 16'd3, 1'b1, 1'b0);
      queue_byte(8'h5a, 16'h0001, 1'b1, 1'b1);

      load_seed(32'h0000_0000);
      queue_random_items(175);
      load_seed(32'hffff_ffff);
      queue_random_items(175);

      load_seed($urandom);
      queue_random_items(40);

      load_seed($urandom);
      queue_random_items(150);
      drain_results();
      @(posedge clock);
      calm = 1'b1;
      queue_random_items(160);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (hashes_due.size() != 0) begin
         report_failure($sformatf("%0d hashes never arrived", hashes_due.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
